[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the flood forward controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/ffc_pkg.sv]
// ----------------------------------------------------------------------------
// ffc_pkg
// Types and constants shared by the flood forward controller modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffc_pkg;

  localparam int ADDR_BITS_DEFAULT = 16;
  localparam int FIELD_ADDR_W      = 16;
  localparam int PADDR_W           = 4;
  localparam int PDATA_W           = 32;

  localparam logic [15:0] NODE_ADDR_RST   = 16'd0;
  localparam logic [15:0] QUEUE_TICKS_RST = 16'd32;
  localparam logic [7:0]  MAX_HOPS_RST    = 8'd16;
  localparam logic        RECV_PRES_RST   = 1'b1;

  typedef enum logic [1:0] {
    OP_RX     = 2'd0,
    OP_SEND   = 2'd1,
    OP_TICK   = 2'd2,
    OP_CANCEL = 2'd3
  } ffc_op_t;

  typedef enum logic [1:0] {
    REG_NODE_ADDR   = 2'd0,
    REG_QUEUE_TICKS = 2'd1,
    REG_MAX_HOPS    = 2'd2,
    REG_RECV_PRES   = 2'd3
  } ffc_reg_t;

  typedef struct packed {
    logic [15:0] node_addr;
    logic [15:0] queue_ticks;
    logic [7:0]  max_hops;
    logic        receiver_present;
  } ffc_cfg_t;

  typedef struct packed {
    logic        deliver;
    logic        queued;
    logic        transmit;
    logic [15:0] tx_originator;
    logic [7:0]  tx_seqno;
    logic [7:0]  tx_hops;
  } ffc_result_t;

  typedef struct packed {
    logic        pending_valid;
    logic        timer_active;
    logic [15:0] timer_left;
  } ffc_status_t;

endpackage

[rtl/flood_forward_controller_unit.sv]
// An accepted request is held in the input register, then its result is captured in the result register.
// Throughput: one request per cycle while out_ready takes each result; the input register refills as the
// result register is taken, so both stages move together.
// Reset (synchronous, active low) empties both stages, clears the timer,
// sequence and duplicate state, and loads the register defaults.
// ----------------------------------------------------------------------------
// flood_forward_controller_unit
// Flood relay controller with duplicate suppression and a deferred send timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module flood_forward_controller_unit #(
  parameter int ADDR_BITS = ffc_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [15:0]                 in_originator,
  input  logic [7:0]                  in_orig_seqno,
  input  logic [7:0]                  in_hop_count,
  input  logic                        in_app_accept,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_deliver,
  output logic                        out_queued,
  output logic                        out_transmit,
  output logic [15:0]                 out_tx_originator,
  output logic [7:0]                  out_tx_seqno,
  output logic [7:0]                  out_tx_hops,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffc_pkg::PADDR_W-1:0] paddr,
  input  logic [ffc_pkg::PDATA_W-1:0] pwdata,
  output logic [ffc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import ffc_pkg::*;

  ffc_cfg_t    cfg;
  ffc_result_t res;
  ffc_status_t status;

  logic        s1_vld_r;
  ffc_op_t     s1_op_r;
  logic [15:0] s1_orig_r;
  logic [7:0]  s1_seq_r;
  logic [7:0]  s1_hops_r;
  logic        s1_acc_r;
  logic        out_vld_r;
  ffc_result_t out_r;
  logic        advance;
  logic        step;

  assign advance  = !out_vld_r || out_ready;
  assign step     = s1_vld_r && advance;
  assign in_ready = !s1_vld_r || advance;

  ffc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffc_core #(
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .op         (s1_op_r),
    .originator (s1_orig_r),
    .orig_seqno (s1_seq_r),
    .hop_count  (s1_hops_r),
    .app_accept (s1_acc_r),
    .cfg        (cfg),
    .res        (res),
    .status     (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= ffc_op_t'(in_op);
      s1_orig_r <= in_originator;
      s1_seq_r  <= in_orig_seqno;
      s1_hops_r <= in_hop_count;
      s1_acc_r  <= in_app_accept;
    end
    if (step) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_deliver       = out_r.deliver;
  assign out_queued        = out_r.queued;
  assign out_transmit      = out_r.transmit;
  assign out_tx_originator = out_r.tx_originator;
  assign out_tx_seqno      = out_r.tx_seqno;
  assign out_tx_hops       = out_r.tx_hops;

  `FFC_ASSERT_NEXT(a_queue_arms_timer, clk, rst_n, step && res.queued, status.timer_active)
  `FFC_ASSERT_NEXT(a_send_clears_pending, clk, rst_n, step && res.transmit,
    !status.pending_valid)
  `FFC_ASSERT_SAME(a_timer_left_tracks_active, clk, rst_n, 1'b1,
    status.timer_active == (status.timer_left != 16'd0))

endmodule

[rtl/ffc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ffc_cfg_regs
// APB register file holding the controller configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffc_pkg::PADDR_W-1:0] paddr,
  input  logic [ffc_pkg::PDATA_W-1:0] pwdata,
  output logic [ffc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output ffc_pkg::ffc_cfg_t           cfg
);
  import ffc_pkg::*;

  ffc_cfg_t cfg_r;
  ffc_cfg_t cfg_nxt;
  ffc_reg_t reg_idx;
  logic     wr_en;

  assign reg_idx = ffc_reg_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_NODE_ADDR:   cfg_nxt.node_addr        = pwdata[15:0];
        REG_QUEUE_TICKS: cfg_nxt.queue_ticks      = pwdata[15:0];
        REG_MAX_HOPS:    cfg_nxt.max_hops         = pwdata[7:0];
        REG_RECV_PRES:   cfg_nxt.receiver_present = pwdata[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NODE_ADDR:   prdata = PDATA_W'(cfg_r.node_addr);
      REG_QUEUE_TICKS: prdata = PDATA_W'(cfg_r.queue_ticks);
      REG_MAX_HOPS:    prdata = PDATA_W'(cfg_r.max_hops);
      REG_RECV_PRES:   prdata = PDATA_W'(cfg_r.receiver_present);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_addr        <= NODE_ADDR_RST;
      cfg_r.queue_ticks      <= QUEUE_TICKS_RST;
      cfg_r.max_hops         <= MAX_HOPS_RST;
      cfg_r.receiver_present <= RECV_PRES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/ffc_core.sv]
// ----------------------------------------------------------------------------
// ffc_core
// Duplicate check, relay queueing and send timer for one request per cycle while step is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffc_core #(
  parameter int ADDR_BITS = ffc_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  ffc_pkg::ffc_op_t       op,
  input  logic [15:0]            originator,
  input  logic [7:0]             orig_seqno,
  input  logic [7:0]             hop_count,
  input  logic                   app_accept,
  input  ffc_pkg::ffc_cfg_t      cfg,
  output ffc_pkg::ffc_result_t   res,
  output ffc_pkg::ffc_status_t   status
);
  import ffc_pkg::*;

  localparam int AW = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;

  logic [7:0]    own_seq_r,   own_seq_nxt;
  logic [AW-1:0] last_orig_r, last_orig_nxt;
  logic [7:0]    last_seq_r,  last_seq_nxt;
  logic          pend_vld_r,  pend_vld_nxt;
  logic [AW-1:0] pend_orig_r, pend_orig_nxt;
  logic [7:0]    pend_seq_r,  pend_seq_nxt;
  logic [7:0]    pend_hops_r, pend_hops_nxt;
  logic [7:0]    heard_r,     heard_nxt;
  logic [15:0]   left_r,      left_nxt;
  logic          active_r,    active_nxt;

  logic [AW-1:0] orig_m;
  logic [AW-1:0] me;
  logic [15:0]   arm_ticks;
  logic          dup;

  assign orig_m    = originator[AW-1:0];
  assign me        = cfg.node_addr[AW-1:0];
  assign arm_ticks = (cfg.queue_ticks == 16'd0) ? 16'd1 : cfg.queue_ticks;
  assign dup       = (orig_m == last_orig_r) && (orig_seqno <= last_seq_r);

  assign status.pending_valid = pend_vld_r;
  assign status.timer_active  = active_r;
  assign status.timer_left    = left_r;

  always_comb begin
    own_seq_nxt   = own_seq_r;
    last_orig_nxt = last_orig_r;
    last_seq_nxt  = last_seq_r;
    pend_vld_nxt  = pend_vld_r;
    pend_orig_nxt = pend_orig_r;
    pend_seq_nxt  = pend_seq_r;
    pend_hops_nxt = pend_hops_r;
    heard_nxt     = heard_r;
    left_nxt      = left_r;
    active_nxt    = active_r;
    res           = '0;
    case (op)
      OP_RX: begin
        if (heard_r != 8'hFF) begin
          heard_nxt = heard_r + 8'd1;
        end
        if (cfg.receiver_present && !dup) begin
          res.deliver = 1'b1;
          if (app_accept && (hop_count < cfg.max_hops)) begin
            if (!pend_vld_r) begin
              pend_orig_nxt = orig_m;
              pend_seq_nxt  = orig_seqno;
              pend_hops_nxt = hop_count + 8'd1;
              pend_vld_nxt  = 1'b1;
            end
            heard_nxt     = 8'd0;
            left_nxt      = arm_ticks;
            active_nxt    = 1'b1;
            res.queued    = 1'b1;
            last_orig_nxt = orig_m;
            last_seq_nxt  = orig_seqno;
          end
        end
      end
      OP_SEND: begin
        own_seq_nxt   = own_seq_r + 8'd1;
        pend_orig_nxt = me;
        pend_seq_nxt  = own_seq_nxt;
        pend_hops_nxt = 8'd0;
        pend_vld_nxt  = 1'b1;
        last_orig_nxt = me;
        last_seq_nxt  = own_seq_nxt;
        heard_nxt     = 8'd0;
        left_nxt      = arm_ticks;
        active_nxt    = 1'b1;
        res.queued    = 1'b1;
      end
      OP_TICK: begin
        if (active_r) begin
          if (left_r <= 16'd1) begin
            if (heard_r != 8'd0) begin
              heard_nxt  = 8'd0;
              left_nxt   = arm_ticks;
              active_nxt = 1'b1;
            end else begin
              active_nxt = 1'b0;
              left_nxt   = 16'd0;
              if (pend_vld_r) begin
                res.transmit      = 1'b1;
                res.tx_originator = FIELD_ADDR_W'(pend_orig_r);
                res.tx_seqno      = pend_seq_r;
                res.tx_hops       = pend_hops_r;
                pend_vld_nxt      = 1'b0;
              end
            end
          end else begin
            left_nxt = left_r - 16'd1;
          end
        end
      end
      OP_CANCEL: begin
        active_nxt = 1'b0;
        left_nxt   = 16'd0;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_seq_r   <= '0;
      last_orig_r <= '0;
      last_seq_r  <= '0;
      pend_vld_r  <= 1'b0;
      heard_r     <= '0;
      left_r      <= '0;
      active_r    <= 1'b0;
    end else if (step) begin
      own_seq_r   <= own_seq_nxt;
      last_orig_r <= last_orig_nxt;
      last_seq_r  <= last_seq_nxt;
      pend_vld_r  <= pend_vld_nxt;
      heard_r     <= heard_nxt;
      left_r      <= left_nxt;
      active_r    <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pend_orig_r <= pend_orig_nxt;
      pend_seq_r  <= pend_seq_nxt;
      pend_hops_r <= pend_hops_nxt;
    end
  end

endmodule
